/* design/grm_pkg.sv */
// Shared constants, codes and types of the grid ray marcher.
package grm_pkg;

    localparam int MAP_W_DEF = 32;
    localparam int MAP_H_DEF = 16;

    localparam int PT_W      = 32;
    localparam int FRAC_BITS = 22;
    localparam int TEX_BITS  = 8;
    localparam int DIR_SHIFT = 14;

    localparam logic [FRAC_BITS-1:0] HALF_FRAC = FRAC_BITS'(1) << (FRAC_BITS - 1);

    localparam logic [7:0]  MARCH_STEP_RST = 8'd20;
    localparam logic [12:0] MAX_DIST_RST   = 13'd4096;

    localparam logic CFG_MARCH_STEP = 1'b0;
    localparam logic CFG_MAX_DIST   = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CAST = 1'b1;

    typedef enum logic [1:0] {
        KIND_MAX  = 2'd0,
        KIND_WALL = 2'd1,
        KIND_LEFT = 2'd2
    } hit_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_MARCH
    } state_t;

endpackage

/* design/grm_map.sv */
// Wall map: one bit per cell, row writes and a single cell read port.
module grm_map #(
    parameter int MAP_W = grm_pkg::MAP_W_DEF,
    parameter int MAP_H = grm_pkg::MAP_H_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  logic [3:0]               wr_row,
    input  logic [31:0]              wr_bits,
    input  logic [$clog2(MAP_W)-1:0] rd_col,
    input  logic [$clog2(MAP_H)-1:0] rd_row,
    output logic                     rd_wall
);

    logic [MAP_W-1:0] rows_reg [MAP_H];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < MAP_H; r++) begin
                rows_reg[r] <= '0;
            end
        end else begin
            for (int r = 0; r < MAP_H; r++) begin
                if (wr_en && (int'(wr_row) == r)) begin
                    rows_reg[r] <= MAP_W'(64'(wr_bits));
                end
            end
        end
    end

    always_comb begin
        if ((int'(rd_row) < MAP_H) && (int'(rd_col) < MAP_W)) begin
            rd_wall = rows_reg[rd_row][rd_col];
        end else begin
            rd_wall = 1'b0;
        end
    end

endmodule

/* design/grid_ray_marcher.sv */
// Grid ray marcher top level: configuration, step sequencer and result register.
//
// A load word writes one map row. A cast word is first taken in, then the sample point
// advances once per march step, and a final test ends the march; it ends early when a
// wall is hit or the ray leaves the map, else when the distance reaches max_distance.
// The stepping is the single add-and-test step loop, which advances the sample point by
// a precomputed increment each cycle until the march stops. The map is cleared at reset.
// The result sits in an output register, so a new word is taken while the last result
// waits; a cast that finishes before that result is taken holds until it is.
module grid_ray_marcher #(
    parameter int MAP_W = grm_pkg::MAP_W_DEF,
    parameter int MAP_H = grm_pkg::MAP_H_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [12:0]        cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [3:0]         s_row_index,
    input  logic [31:0]        s_row_bits,
    input  logic [12:0]        s_player_x,
    input  logic [11:0]        s_player_y,
    input  logic signed [15:0] s_dir_x,
    input  logic signed [15:0] s_dir_y,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_distance,
    output logic [1:0]         m_hit_kind,
    output logic [4:0]         m_hit_cell_x,
    output logic [3:0]         m_hit_cell_y,
    output logic [7:0]         m_tex_u
);

    localparam int PT_W   = grm_pkg::PT_W;
    localparam int FB     = grm_pkg::FRAC_BITS;
    localparam int CELL_W = PT_W - FB;
    localparam int COL_W  = $clog2(MAP_W);
    localparam int ROW_W  = $clog2(MAP_H);

    grm_pkg::state_t state_reg, state_next;

    logic [7:0]  march_step_reg;
    logic [12:0] max_dist_reg;

    logic signed [PT_W-1:0] hx_reg, hy_reg;
    logic signed [PT_W-1:0] dxs_reg, dys_reg;
    logic [13:0]            dist_reg;
    logic                   pt_valid_reg;

    logic        m_valid_reg;
    logic [13:0] m_distance_reg;
    logic [1:0]  m_hit_kind_reg;
    logic [4:0]  m_hit_cell_x_reg;
    logic [3:0]  m_hit_cell_y_reg;
    logic [7:0]  m_tex_u_reg;

    logic [7:0]         step_eff;
    logic signed [24:0] prod_x, prod_y;
    logic [13:0]        dist_next;

    logic [CELL_W-1:0] cx, cy;
    logic              left_now, wall_now, hit_now, march_stop;
    logic              rd_wall;

    logic [FB-1:0]        fx, fy;
    logic signed [FB:0]   ox, oy;
    logic [FB:0]          ax, ay;
    logic                 use_x;
    logic [7:0]           tex_now;

    logic cast_go, load_go, out_free, finish, issue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            march_step_reg <= grm_pkg::MARCH_STEP_RST;
            max_dist_reg   <= grm_pkg::MAX_DIST_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                grm_pkg::CFG_MARCH_STEP: march_step_reg <= cfg_data[7:0];
                grm_pkg::CFG_MAX_DIST:   max_dist_reg   <= cfg_data;
            endcase
        end
    end

    assign step_eff  = (march_step_reg == '0) ? 8'd1 : march_step_reg;
    assign prod_x    = s_dir_x * $signed({1'b0, step_eff});
    assign prod_y    = s_dir_y * $signed({1'b0, step_eff});
    assign dist_next = dist_reg + 14'(step_eff);

    assign cx = hx_reg[PT_W-1:FB];
    assign cy = hy_reg[PT_W-1:FB];

    grm_map #(
        .MAP_W(MAP_W),
        .MAP_H(MAP_H)
    ) u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (load_go),
        .wr_row  (s_row_index),
        .wr_bits (s_row_bits),
        .rd_col  (cx[COL_W-1:0]),
        .rd_row  (cy[ROW_W-1:0]),
        .rd_wall (rd_wall)
    );

    assign left_now = hx_reg[PT_W-1] || hy_reg[PT_W-1]
                   || (cx >= CELL_W'(MAP_W)) || (cy >= CELL_W'(MAP_H));
    assign wall_now = rd_wall;
    assign hit_now  = pt_valid_reg && (left_now || wall_now);

    assign fx = hx_reg[FB-1:0];
    assign fy = hy_reg[FB-1:0];
    assign ox = $signed({1'b0, fx}) - $signed({1'b0, grm_pkg::HALF_FRAC});
    assign oy = $signed({1'b0, fy}) - $signed({1'b0, grm_pkg::HALF_FRAC});
    assign ax = ox[FB] ? unsigned'(-ox) : unsigned'(ox);
    assign ay = oy[FB] ? unsigned'(-oy) : unsigned'(oy);
    assign use_x   = (ay > ax) || ((fy == fx) && (fx > grm_pkg::HALF_FRAC));
    assign tex_now = use_x ? hx_reg[FB-1 -: grm_pkg::TEX_BITS]
                           : hy_reg[FB-1 -: grm_pkg::TEX_BITS];

    always_comb begin
        s_ready    = (state_reg == grm_pkg::ST_IDLE);
        cast_go    = s_valid && s_ready && (s_operation == grm_pkg::OP_CAST);
        load_go    = s_valid && s_ready && (s_operation == grm_pkg::OP_LOAD);
        out_free   = !m_valid_reg || m_ready;
        march_stop = hit_now || (dist_reg >= {1'b0, max_dist_reg});
        finish     = (state_reg == grm_pkg::ST_MARCH) && march_stop && out_free;
        issue      = (state_reg == grm_pkg::ST_MARCH) && !march_stop;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            grm_pkg::ST_IDLE: begin
                if (cast_go) begin
                    state_next = grm_pkg::ST_MARCH;
                end
            end
            grm_pkg::ST_MARCH: begin
                if (finish) begin
                    state_next = grm_pkg::ST_IDLE;
                end
            end
            default: state_next = grm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= grm_pkg::ST_IDLE;
            pt_valid_reg <= 1'b0;
            dist_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cast_go) begin
                pt_valid_reg <= 1'b0;
                dist_reg     <= '0;
            end else if (issue) begin
                pt_valid_reg <= 1'b1;
                dist_reg     <= dist_next;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cast_go) begin
            hx_reg  <= $signed({5'b0, s_player_x, {grm_pkg::DIR_SHIFT{1'b0}}});
            hy_reg  <= $signed({6'b0, s_player_y, {grm_pkg::DIR_SHIFT{1'b0}}});
            dxs_reg <= PT_W'(prod_x);
            dys_reg <= PT_W'(prod_y);
        end else if (issue) begin
            hx_reg <= hx_reg + dxs_reg;
            hy_reg <= hy_reg + dys_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_hit_cell_x_reg <= '0;
            m_hit_cell_y_reg <= '0;
            m_tex_u_reg      <= '0;
            if (hit_now && left_now) begin
                m_distance_reg <= {1'b0, max_dist_reg};
                m_hit_kind_reg <= grm_pkg::KIND_LEFT;
            end else if (hit_now) begin
                m_distance_reg   <= dist_reg;
                m_hit_kind_reg   <= grm_pkg::KIND_WALL;
                m_hit_cell_x_reg <= cx[4:0];
                m_hit_cell_y_reg <= cy[3:0];
                m_tex_u_reg      <= tex_now;
            end else begin
                m_distance_reg <= dist_reg;
                m_hit_kind_reg <= grm_pkg::KIND_MAX;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_distance   = m_distance_reg;
    assign m_hit_kind   = m_hit_kind_reg;
    assign m_hit_cell_x = m_hit_cell_x_reg;
    assign m_hit_cell_y = m_hit_cell_y_reg;
    assign m_tex_u      = m_tex_u_reg;

    a_cast_starts_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        cast_go |=> (state_reg == grm_pkg::ST_MARCH) && !pt_valid_reg && (dist_reg == '0))
        else $error("cast did not start a clean march");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == grm_pkg::ST_MARCH) |-> !s_ready)
        else $error("input taken while marching");

    a_point_has_distance: assert property (@(posedge aclk) disable iff (!aresetn)
        pt_valid_reg |-> (dist_reg != '0))
        else $error("sample point without distance");

    a_finish_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> !(finish && $past(m_valid_reg && !m_ready)) || m_ready
                                   || !m_valid_reg || $stable(m_distance_reg))
        else $error("pending result overwritten");

    a_idle_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_hit_kind != 2'(grm_pkg::KIND_WALL)))
            |-> (m_tex_u == '0) && (m_hit_cell_x == '0) && (m_hit_cell_y == '0))
        else $error("non-wall result carries cell fields");

    a_left_at_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_hit_kind == 2'(grm_pkg::KIND_LEFT)))
            |-> (m_distance == {1'b0, max_dist_reg}))
        else $error("left-map result with wrong distance");

endmodule
